// ===== rtl/apht_pkg.sv =====
// Shared constants for the arc point hit test unit.
// Holds the CORDIC arctangent table, datapath widths and config register indexes.
package apht_pkg;

  localparam int DEF_COORD_WIDTH   = 32;
  localparam int DEF_ANGLE_WIDTH   = 16;
  localparam int DEF_CORDIC_STAGES = 16;

  // turn accumulator, 2^Z_W units per turn
  localparam int Z_W       = 32;
  // CORDIC x/y datapath, normalized magnitude lies in [2^51, 2^52)
  localparam int CX_W      = 56;
  localparam int NORM_W    = 52;
  localparam int NORM_STEPS = 6;
  localparam int NORM_FIRST = 32;
  localparam int ATAN_LEN  = 24;

  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  localparam logic [Z_W-1:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_TOL     = 3'd5;

endpackage

// ===== rtl/arc_point_hit_test_unit.sv =====
// An accepted item passes stage 0, then the radial and CORDIC stages, then the output stage.
// Throughput: one item per cycle while the output is not stalled; one CORDIC micro-rotation per rotation stage.
// A stalled output holds only the stages behind it; empty stages keep filling.
// Reset (rst_n low, synchronous) clears all valid bits and all config registers to zero.
// Top level: config registers, difference stage, valid chain, output stage.
// Depends on apht_pkg, apht_radial, apht_cordic.
module arc_point_hit_test_unit #(
  parameter int COORD_WIDTH   = apht_pkg::DEF_COORD_WIDTH,
  parameter int ANGLE_WIDTH   = apht_pkg::DEF_ANGLE_WIDTH,
  parameter int CORDIC_STAGES = apht_pkg::DEF_CORDIC_STAGES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_point_x,
  input  logic signed [COORD_WIDTH-1:0]         in_point_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_on_arc,
  output logic                                  out_radius_ok,
  output logic                                  out_angle_ok,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [apht_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data
);
  import apht_pkg::*;

  localparam int NumStg = CORDIC_STAGES + 5;
  localparam int OutStg = NumStg - 1;
  localparam int DW     = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] center_x_r, center_y_r;
  logic [COORD_WIDTH-2:0]        arc_radius_r, hit_tol_r;
  logic [ANGLE_WIDTH-1:0]        start_angle_r, end_angle_r;

  logic [NumStg-1:0]             vld_r, en;
  logic signed [DW-1:0]          dx_r, dy_r;
  logic [COORD_WIDTH-1:0]        r_hi_r, r_lo_r;

  logic                          rad_ok, zero_pt, ang_ok;
  logic [ANGLE_WIDTH-1:0]        ang, rel, sweep;
  logic                          on_arc_r, radius_ok_r, angle_ok_r;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      arc_radius_r  <= '0;
      hit_tol_r     <= '0;
      start_angle_r <= '0;
      end_angle_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X:    center_x_r    <= cfg_data[COORD_WIDTH-1:0];
        CFG_CENTER_Y:    center_y_r    <= cfg_data[COORD_WIDTH-1:0];
        CFG_ARC_RADIUS:  arc_radius_r  <= cfg_data[COORD_WIDTH-2:0];
        CFG_START_ANGLE: start_angle_r <= cfg_data[ANGLE_WIDTH-1:0];
        CFG_END_ANGLE:   end_angle_r   <= cfg_data[ANGLE_WIDTH-1:0];
        CFG_HIT_TOL:     hit_tol_r     <= cfg_data[COORD_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  // stage k may load when some stage at or after it is empty, or the output drains
  for (genvar k = 0; k < NumStg; k++) begin : g_en
    assign en[k] = out_ready || !(&vld_r[OutStg:k]);
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 0: offsets from center and radial bounds
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r   <= {in_point_x[COORD_WIDTH-1], in_point_x} - {center_x_r[COORD_WIDTH-1], center_x_r};
      dy_r   <= {in_point_y[COORD_WIDTH-1], in_point_y} - {center_y_r[COORD_WIDTH-1], center_y_r};
      r_hi_r <= {1'b0, arc_radius_r} + {1'b0, hit_tol_r};
      r_lo_r <= (arc_radius_r > hit_tol_r) ? {1'b0, arc_radius_r - hit_tol_r} : '0;
    end
  end

  apht_radial #(
    .COORD_WIDTH(COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_radial (
    .clk(clk),
    .stg_en(en[OutStg-1:1]),
    .dx(dx_r),
    .dy(dy_r),
    .r_hi(r_hi_r),
    .r_lo(r_lo_r),
    .rad_ok(rad_ok)
  );

  apht_cordic #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk(clk),
    .stg_en(en[OutStg-1:1]),
    .dx(dx_r),
    .dy(dy_r),
    .ang(ang),
    .zero_pt(zero_pt)
  );

  // output stage: angle relative to start, wrapped, against the sweep
  assign rel    = ang - start_angle_r;
  assign sweep  = end_angle_r - start_angle_r;
  assign ang_ok = zero_pt || (rel <= sweep);

  always_ff @(posedge clk) begin
    if (en[OutStg]) begin
      on_arc_r    <= rad_ok && ang_ok;
      radius_ok_r <= rad_ok;
      angle_ok_r  <= ang_ok;
    end
  end

  assign out_valid     = vld_r[OutStg];
  assign out_on_arc    = on_arc_r;
  assign out_radius_ok = radius_ok_r;
  assign out_angle_ok  = angle_ok_r;

  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!vld_r[OutStg] || out_ready) |-> in_ready)
    else $error("input stalled while output drains");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  a_on_arc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_on_arc == (out_radius_ok && out_angle_ok)))
    else $error("on_arc inconsistent with radial and angular results");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !en[0]) |=> vld_r[0])
    else $error("stalled first stage lost its item");

endmodule

// ===== rtl/apht_square.sv =====
// Two-stage unsigned squarer built from half-width partial products.
// Depends on apht_pkg for the default width.
module apht_square #(
  parameter int WIDTH = apht_pkg::DEF_COORD_WIDTH + 1
) (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  logic [WIDTH-1:0]   a,
  output logic [2*WIDTH-1:0] sq
);
  localparam int LoW = (WIDTH + 1) / 2;
  localparam int HiW = WIDTH - LoW;

  logic [LoW-1:0]       lo;
  logic [HiW-1:0]       hi;
  logic [2*LoW-1:0]     ll_r;
  logic [WIDTH-1:0]     hl_r;
  logic [2*HiW-1:0]     hh_r;
  logic [2*WIDTH-1:0]   sq_r;

  assign lo = a[LoW-1:0];
  assign hi = a[WIDTH-1:LoW];

  always_ff @(posedge clk) begin
    if (en_a) begin
      ll_r <= lo * lo;
      hl_r <= hi * lo;
      hh_r <= hi * hi;
    end
  end

  // a^2 = hh<<2L + 2*hl<<L + ll
  always_ff @(posedge clk) begin
    if (en_b) begin
      sq_r <= {hh_r, ll_r} + (2*WIDTH)'({hl_r, {(LoW+1){1'b0}}});
    end
  end

  assign sq = sq_r;

endmodule

// ===== rtl/apht_radial.sv =====
// Radial test: squared distance against squared radius bounds, then delay
// to line up with the angle path. Depends on apht_pkg and apht_square.
module apht_radial #(
  parameter int COORD_WIDTH   = apht_pkg::DEF_COORD_WIDTH,
  parameter int CORDIC_STAGES = apht_pkg::DEF_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic [CORDIC_STAGES+2:0]      stg_en,   // bit j loads stage j+1
  input  logic signed [COORD_WIDTH:0]   dx,
  input  logic signed [COORD_WIDTH:0]   dy,
  input  logic [COORD_WIDTH-1:0]        r_hi,
  input  logic [COORD_WIDTH-1:0]        r_lo,
  output logic                          rad_ok
);
  import apht_pkg::*;

  localparam int MW = COORD_WIDTH + 1;
  localparam int SW = 2 * MW;
  localparam int OkLen = CORDIC_STAGES - 1;

  logic [MW-1:0] ma_r, mb_r, ra_r, rb_r;
  logic [SW-1:0] sqa, sqb, sqh, sql;
  logic [SW:0]   d2_r, hi2_r, lo2_r;
  logic          ok_r [OkLen];

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      ma_r <= dx[MW-1] ? -dx : dx;
      mb_r <= dy[MW-1] ? -dy : dy;
      ra_r <= {1'b0, r_hi};
      rb_r <= {1'b0, r_lo};
    end
  end

  // stages 2 and 3: squares
  apht_square #(.WIDTH(MW)) u_sq_a (
    .clk(clk), .en_a(stg_en[1]), .en_b(stg_en[2]), .a(ma_r), .sq(sqa));
  apht_square #(.WIDTH(MW)) u_sq_b (
    .clk(clk), .en_a(stg_en[1]), .en_b(stg_en[2]), .a(mb_r), .sq(sqb));
  apht_square #(.WIDTH(MW)) u_sq_h (
    .clk(clk), .en_a(stg_en[1]), .en_b(stg_en[2]), .a(ra_r), .sq(sqh));
  apht_square #(.WIDTH(MW)) u_sq_l (
    .clk(clk), .en_a(stg_en[1]), .en_b(stg_en[2]), .a(rb_r), .sq(sql));

  // stage 4: distance squared
  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      d2_r  <= {1'b0, sqa} + {1'b0, sqb};
      hi2_r <= {1'b0, sqh};
      lo2_r <= {1'b0, sql};
    end
  end

  // stage 5: bounds, then delay line to stage CORDIC_STAGES+3
  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      ok_r[0] <= (d2_r <= hi2_r) && (lo2_r <= d2_r);
    end
    for (int j = 1; j < OkLen; j++) begin
      if (stg_en[4+j]) begin
        ok_r[j] <= ok_r[j-1];
      end
    end
  end

  assign rad_ok = ok_r[OkLen-1];

endmodule

// ===== rtl/apht_cordic.sv =====
// Vectoring CORDIC angle pipeline: half-turn fold, normalize, micro-rotations.
// Depends on apht_pkg for the arctangent table and datapath widths.
module apht_cordic #(
  parameter int COORD_WIDTH   = apht_pkg::DEF_COORD_WIDTH,
  parameter int ANGLE_WIDTH   = apht_pkg::DEF_ANGLE_WIDTH,
  parameter int CORDIC_STAGES = apht_pkg::DEF_CORDIC_STAGES
) (
  input  logic                        clk,
  input  logic [CORDIC_STAGES+2:0]    stg_en,   // bit j loads stage j+1
  input  logic signed [COORD_WIDTH:0] dx,
  input  logic signed [COORD_WIDTH:0] dy,
  output logic [ANGLE_WIDTH-1:0]      ang,
  output logic                        zero_pt
);
  import apht_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic [DW-1:0]          adx, ady;
  logic signed [DW:0]     dy_e;
  logic [DW-1:0]          x1_r, mx1_r;
  logic signed [DW:0]     y1_r;
  logic                   neg1_r, zero1_r;

  logic signed [CX_W-1:0] xa, ya, xb, yb;
  logic [NORM_W-1:0]      ma, mb;
  logic signed [CX_W-1:0] x2_r, y2_r, x3_r, y3_r;
  logic [NORM_W-1:0]      m2_r;
  logic                   neg2_r, zero2_r, neg3_r, zero3_r;

  logic signed [CX_W-1:0] x_in [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_in [CORDIC_STAGES];
  logic [Z_W-1:0]         z_in [CORDIC_STAGES];
  logic                   zf_in [CORDIC_STAGES];
  logic signed [CX_W-1:0] x_nxt [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_nxt [CORDIC_STAGES];
  logic [Z_W-1:0]         z_nxt [CORDIC_STAGES];
  logic signed [CX_W-1:0] x_r [CORDIC_STAGES];
  logic signed [CX_W-1:0] y_r [CORDIC_STAGES];
  logic [Z_W-1:0]         z_r [CORDIC_STAGES];
  logic                   zf_r [CORDIC_STAGES];

  // stage 1: fold into the right half plane
  assign adx  = dx[DW-1] ? -dx : dx;
  assign ady  = dy[DW-1] ? -dy : dy;
  assign dy_e = {dy[DW-1], dy};

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      x1_r    <= adx;
      y1_r    <= dx[DW-1] ? -dy_e : dy_e;
      mx1_r   <= (adx > ady) ? adx : ady;
      neg1_r  <= dx[DW-1];
      zero1_r <= (dx == '0) && (dy == '0);
    end
  end

  // stages 2 and 3: shift until the larger magnitude reaches 2^(NORM_W-1)
  always_comb begin
    int sh;
    xa = CX_W'(x1_r);
    ya = {{(CX_W-DW-1){y1_r[DW]}}, y1_r};
    ma = NORM_W'(mx1_r);
    for (int j = 0; j < NORM_STEPS / 2; j++) begin
      sh = NORM_FIRST >> j;
      if ((ma >> (NORM_W - sh)) == '0) begin
        ma = ma << sh;
        xa = xa <<< sh;
        ya = ya <<< sh;
      end
    end
  end

  always_comb begin
    int sh;
    xb = x2_r;
    yb = y2_r;
    mb = m2_r;
    for (int j = NORM_STEPS / 2; j < NORM_STEPS; j++) begin
      sh = NORM_FIRST >> j;
      if ((mb >> (NORM_W - sh)) == '0) begin
        mb = mb << sh;
        xb = xb <<< sh;
        yb = yb <<< sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      x2_r    <= xa;
      y2_r    <= ya;
      m2_r    <= ma;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
    end
    if (stg_en[2]) begin
      x3_r    <= xb;
      y3_r    <= yb;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  // stages 4 .. CORDIC_STAGES+3: one micro-rotation each
  always_comb begin
    x_in[0]  = x3_r;
    y_in[0]  = y3_r;
    z_in[0]  = neg3_r ? HALF_TURN : '0;
    zf_in[0] = zero3_r;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      x_in[i]  = x_r[i-1];
      y_in[i]  = y_r[i-1];
      z_in[i]  = z_r[i-1];
      zf_in[i] = zf_r[i-1];
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y_in[i][CX_W-1]) begin
        x_nxt[i] = x_in[i] - (y_in[i] >>> i);
        y_nxt[i] = y_in[i] + (x_in[i] >>> i);
        z_nxt[i] = z_in[i] - ATAN_TURN[i];
      end else begin
        x_nxt[i] = x_in[i] + (y_in[i] >>> i);
        y_nxt[i] = y_in[i] - (x_in[i] >>> i);
        z_nxt[i] = z_in[i] + ATAN_TURN[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (stg_en[3+i]) begin
        x_r[i]  <= x_nxt[i];
        y_r[i]  <= y_nxt[i];
        z_r[i]  <= z_nxt[i];
        zf_r[i] <= zf_in[i];
      end
    end
  end

  assign ang     = z_r[CORDIC_STAGES-1][Z_W-1 -: ANGLE_WIDTH];
  assign zero_pt = zf_r[CORDIC_STAGES-1];

endmodule
